### src/chd_pkg.sv
// Shared types and constants for the canonical Huffman decoder.
package chd_pkg;

    localparam int COUNT_DEPTH = 16;
    localparam int COUNT_IDX_W = 4;

    typedef logic [8:0] t_count;

    typedef enum logic [1:0] {
        MODE_COUNT  = 2'd0,
        MODE_SYMBOL = 2'd1,
        MODE_DATA   = 2'd2,
        MODE_END    = 2'd3
    } t_mode;

    typedef struct packed {
        logic        result;
        logic        err;
        logic [8:0]  slot;
        logic [15:0] partial;
        logic [15:0] first;
        logic [8:0]  base;
        logic [3:0]  bit_len;
    } t_step;

endpackage

### src/chd_step.sv
// One-bit canonical decode step: length test, slot arithmetic and next state.
module chd_step #(
    parameter int MAX_CODE_LEN = 15,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic           i_bit,
    input  logic [15:0]    i_partial,
    input  logic [15:0]    i_first,
    input  logic [8:0]     i_base,
    input  logic [3:0]     i_bit_len,
    input  chd_pkg::t_count i_counts [chd_pkg::COUNT_DEPTH],
    output chd_pkg::t_step o_step
);
    import chd_pkg::*;

    localparam logic [4:0] MAX_LEN = 5'(MAX_CODE_LEN);
    localparam logic [8:0] NUM_SYM = 9'(NUM_SYMBOLS);

    logic [4:0]  len;
    logic [15:0] code;
    t_count      count;
    logic [16:0] limit;
    logic        match;
    logic [8:0]  slot;
    logic [8:0]  base_next;

    always_comb begin
        len       = {1'b0, i_bit_len} + 5'd1;
        code      = {i_partial[14:0], i_bit};
        count     = i_counts[len[COUNT_IDX_W-1:0]];
        limit     = {1'b0, i_first} + {8'd0, count};
        match     = {1'b0, code} < limit;
        slot      = i_base + code[8:0] - i_first[8:0];
        base_next = i_base + count;

        o_step.result  = match || (len >= MAX_LEN);
        o_step.err     = match ? (slot >= NUM_SYM) : 1'b1;
        o_step.slot    = slot;
        o_step.partial = code;
        o_step.first   = {limit[14:0], 1'b0};
        o_step.base    = base_next;
        o_step.bit_len = len[3:0];
    end

endmodule

### src/chd_symtab.sv
// Symbol table in canonical order: one write port, one registered read port.
module chd_symtab #(
    parameter int NUM_SYMBOLS = 256
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(NUM_SYMBOLS)-1:0] i_wr_addr,
    input  logic [7:0]                     i_wr_data,
    input  logic                           i_rd_en,
    input  logic [$clog2(NUM_SYMBOLS)-1:0] i_rd_addr,
    output logic [7:0]                     o_rd_data
);
    logic [7:0] r_mem [NUM_SYMBOLS];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/canonical_huffman_decoder.sv
// Canonical Huffman decoder top level: table loading, bit sequencer and result register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  input    | i_valid / o_stall  | i_mode, i_table_index, i_table_value,
//           |                    | i_data_byte, i_valid_bits
//  output   | o_valid / i_stall  | o_symbol, o_code_error, o_last
//
//  Table loads and end of block complete in their accepting cycle. A compressed byte is
//  worked from its acceptance to the next: the accepting cycle, one bit per cycle on the
//  single step unit, plus a closing step; valid_bits above eight counts as eight.
//  A decoded symbol is held back until the next one is found or the byte ends, so
//  last is known; a full result register stalls the bit loop.
//  Synchronous reset clears the count table and decode state; the symbol table
//  has no reset and no clearing pass.
module canonical_huffman_decoder #(
    parameter int MAX_CODE_LEN = 15,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_table_index,
    input  logic [8:0] i_table_value,
    input  logic [7:0] i_data_byte,
    input  logic [3:0] i_valid_bits,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_symbol,
    output logic       o_code_error,
    output logic       o_last
);
    import chd_pkg::*;

    localparam int         SYM_AW  = $clog2(NUM_SYMBOLS);
    localparam logic [8:0] MAX_LEN = 9'(MAX_CODE_LEN);
    localparam logic [8:0] NUM_SYM = 9'(NUM_SYMBOLS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BIT  = 2'b10
    } t_state;

    t_state      r_state, n_state;
    t_count      r_counts [COUNT_DEPTH];
    logic [15:0] r_partial, n_partial;
    logic [15:0] r_first, n_first;
    logic [8:0]  r_base, n_base;
    logic [3:0]  r_bit_len, n_bit_len;
    logic [7:0]  r_data, n_data;
    logic [3:0]  r_nbits, n_nbits;
    logic        r_pend_valid, n_pend_valid;
    logic        r_pend_err, n_pend_err;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_symbol, n_out_symbol;
    logic        r_out_err, n_out_err;
    logic        r_out_last, n_out_last;

    t_step       step;
    t_mode       mode;
    logic        in_acc;
    logic        out_free;
    logic        push;
    logic        push_last;
    logic        rd_en;
    logic        wr_en;
    logic [7:0]  mem_q;
    logic [7:0]  pend_symbol;

    assign mode     = t_mode'(i_mode);
    assign o_stall  = (r_state != ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign wr_en    = in_acc && (mode == MODE_SYMBOL) && ({1'b0, i_table_index} < NUM_SYM);
    assign pend_symbol = r_pend_err ? 8'd0 : mem_q;

    chd_step #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_step (
        .i_bit    (r_data[7]),
        .i_partial(r_partial),
        .i_first  (r_first),
        .i_base   (r_base),
        .i_bit_len(r_bit_len),
        .i_counts (r_counts),
        .o_step   (step)
    );

    chd_symtab #(
        .NUM_SYMBOLS(NUM_SYMBOLS)
    ) u_symtab (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(i_table_index[SYM_AW-1:0]),
        .i_wr_data(i_table_value[7:0]),
        .i_rd_en  (rd_en),
        .i_rd_addr(step.slot[SYM_AW-1:0]),
        .o_rd_data(mem_q)
    );

    always_comb begin
        n_state      = r_state;
        n_partial    = r_partial;
        n_first      = r_first;
        n_base       = r_base;
        n_bit_len    = r_bit_len;
        n_data       = r_data;
        n_nbits      = r_nbits;
        n_pend_valid = r_pend_valid;
        n_pend_err   = r_pend_err;
        push         = 1'b0;
        push_last    = 1'b0;
        rd_en        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (mode)
                        MODE_DATA: begin
                            n_data  = i_data_byte;
                            n_nbits = (i_valid_bits > 4'd8) ? 4'd8 : i_valid_bits;
                            n_state = ST_BIT;
                        end
                        MODE_END: begin
                            n_partial = '0;
                            n_first   = '0;
                            n_base    = '0;
                            n_bit_len = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_BIT: begin
                if (r_nbits == 4'd0) begin
                    if (!r_pend_valid) begin
                        n_state = ST_IDLE;
                    end else if (out_free) begin
                        push         = 1'b1;
                        push_last    = 1'b1;
                        n_pend_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else if (!(step.result && r_pend_valid) || out_free) begin
                    n_data  = {r_data[6:0], 1'b0};
                    n_nbits = r_nbits - 4'd1;
                    if (step.result) begin
                        push         = r_pend_valid;
                        rd_en        = !step.err;
                        n_pend_valid = 1'b1;
                        n_pend_err   = step.err;
                        n_partial    = '0;
                        n_first      = '0;
                        n_base       = '0;
                        n_bit_len    = '0;
                    end else begin
                        n_partial = step.partial;
                        n_first   = step.first;
                        n_base    = step.base;
                        n_bit_len = step.bit_len;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_out_valid  = r_out_valid && i_stall;
        n_out_symbol = r_out_symbol;
        n_out_err    = r_out_err;
        n_out_last   = r_out_last;
        if (push) begin
            n_out_valid  = 1'b1;
            n_out_symbol = pend_symbol;
            n_out_err    = r_pend_err;
            n_out_last   = push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_partial    <= '0;
            r_first      <= '0;
            r_base       <= '0;
            r_bit_len    <= '0;
            r_nbits      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < COUNT_DEPTH; k++) begin
                r_counts[k] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_partial    <= n_partial;
            r_first      <= n_first;
            r_base       <= n_base;
            r_bit_len    <= n_bit_len;
            r_nbits      <= n_nbits;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (in_acc && (mode == MODE_COUNT) && (i_table_index != 8'd0)
                    && ({1'b0, i_table_index} <= MAX_LEN)) begin
                r_counts[i_table_index[COUNT_IDX_W-1:0]] <= i_table_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data       <= n_data;
        r_pend_err   <= n_pend_err;
        r_out_symbol <= n_out_symbol;
        r_out_err    <= n_out_err;
        r_out_last   <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_symbol     = r_out_symbol;
    assign o_code_error = r_out_err;
    assign o_last       = r_out_last;

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("symbol still pending while idle");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {5'd0, r_bit_len} < MAX_LEN)
        else $error("partial code reached maximum length");

    a_err_symbol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_code_error) |-> (o_symbol == 8'd0))
        else $error("error result carries a symbol");

    a_nbits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nbits <= 4'd8)
        else $error("bit count beyond a byte");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_last) |=> (r_state == ST_IDLE))
        else $error("last result pushed while byte still in progress");

endmodule
